[rtl/pem_pkg.sv]
// Package for the pad event rotation mapper: payload structs, message codes,
// rotation codes and extra row/column bases. No dependencies.
package pem_pkg;

  localparam logic [3:0] MSG_NOTE_ON     = 4'h9;
  localparam logic [3:0] MSG_CTRL_CHANGE = 4'hb;
  localparam logic [3:0] CHAN_ACCEPTED   = 4'h0;
  localparam logic [3:0] SIDE_KEY_NIBBLE = 4'h8;
  localparam logic [6:0] TOP_CC_FIRST    = 7'h68;
  localparam logic [6:0] TOP_CC_LAST     = 7'h6f;
  localparam logic [6:0] EXT_COL_BASE    = 7'h40;
  localparam logic [6:0] EXT_COL_STEP    = 7'h10;
  localparam logic [6:0] EXT_ROW_BASE    = 7'h60;

  localparam logic [1:0] ROT_0   = 2'd0;
  localparam logic [1:0] ROT_90  = 2'd1;
  localparam logic [1:0] ROT_180 = 2'd2;
  localparam logic [1:0] ROT_270 = 2'd3;

  localparam int unsigned NUM_PADS = 4;

  typedef struct packed {
    logic [1:0] pad_index;
    logic [3:0] message_type;
    logic [3:0] midi_channel;
    logic [6:0] key_number;
    logic [6:0] key_velocity;
  } in_t;

  typedef struct packed {
    logic [3:0] grid_row;
    logic [6:0] grid_column;
    logic [6:0] button_velocity;
  } out_t;

  // remap result handed from the mapping logic to the output stage
  typedef struct packed {
    logic hit;
    out_t res;
  } remap_t;

endpackage

[rtl/pem_remap.sv]
// Combinational button remap for one message under one pad rotation.
// Depends on pem_pkg.
module pem_remap (
  input  pem_pkg::in_t    item_i,
  input  logic [1:0]      rot_i,
  output pem_pkg::remap_t map_o
);

  logic       px, py;
  logic [3:0] lo;
  logic [2:0] hi3, k3;
  logic [6:0] ext_col, ext_row;
  logic       is_side, is_grid, is_top;
  logic [3:0] row;
  logic [6:0] col;

  always_comb begin
    px  = item_i.pad_index[0];
    py  = item_i.pad_index[1];
    lo  = item_i.key_number[3:0];
    hi3 = item_i.key_number[6:4];
    k3  = item_i.key_number[2:0];
    ext_col = pem_pkg::EXT_COL_BASE + (px ? pem_pkg::EXT_COL_STEP : 7'd0);
    // pads 1 and 2 land on the same extra-row codes
    ext_row = pem_pkg::EXT_ROW_BASE + {3'd0, px, 3'd0} + {3'd0, py, 3'd0};

    is_side = (item_i.message_type == pem_pkg::MSG_NOTE_ON) &&
              (lo == pem_pkg::SIDE_KEY_NIBBLE);
    is_grid = (item_i.message_type == pem_pkg::MSG_NOTE_ON) && !lo[3];
    is_top  = (item_i.message_type == pem_pkg::MSG_CTRL_CHANGE) &&
              (item_i.key_number >= pem_pkg::TOP_CC_FIRST) &&
              (item_i.key_number <= pem_pkg::TOP_CC_LAST);

    row = 4'd0;
    col = 7'd0;
    if (is_side) begin
      case (rot_i)
        pem_pkg::ROT_0:   begin col = ext_col;                   row = {py, hi3};  end
        pem_pkg::ROT_90:  begin col = ext_row + {4'd0, ~hi3};    row = 4'd0;       end
        pem_pkg::ROT_180: begin col = ext_col;                   row = {py, ~hi3}; end
        default:          begin col = ext_row + {4'd0, hi3};     row = 4'd0;       end
      endcase
    end else if (is_grid) begin
      case (rot_i)
        pem_pkg::ROT_0:   begin col = {3'd0, px, k3};   row = {py, hi3};  end
        pem_pkg::ROT_90:  begin col = {3'd0, py, ~hi3}; row = {px, k3};   end
        pem_pkg::ROT_180: begin col = {3'd0, px, ~k3};  row = {py, ~hi3}; end
        default:          begin col = {3'd0, py, hi3};  row = {px, ~k3};  end
      endcase
    end else if (is_top) begin
      case (rot_i)
        pem_pkg::ROT_0:   begin col = ext_row + {4'd0, k3};  row = 4'd0;      end
        pem_pkg::ROT_90:  begin col = ext_col;               row = {py, k3};  end
        pem_pkg::ROT_180: begin col = ext_row + {4'd0, ~k3}; row = 4'd0;      end
        default:          begin col = ext_col;               row = {py, ~k3}; end
      endcase
    end

    map_o.hit = (item_i.midi_channel == pem_pkg::CHAN_ACCEPTED) &&
                (is_side || is_grid || is_top);
    map_o.res.grid_row        = row;
    map_o.res.grid_column     = col;
    map_o.res.button_velocity = item_i.key_velocity;
  end

endmodule

[rtl/pad_event_rotation_mapper_unit.sv]
// Top level of the pad event rotation mapper: input register, rotation
// registers, remap logic and output register. Depends on pem_pkg, pem_remap.
//
//   channel | direction | handshake               | payload
//   in      | sink      | in_valid_i / in_ready_o  | in_data_i  (pem_pkg::in_t)
//   out     | source    | out_valid_o / out_ready_i| out_data_o (pem_pkg::out_t)
//   cfg     | sink      | cfg_we_i                 | cfg_index_i, cfg_data_i
//
// One message per cycle sustained while the output is not stalled; a result
// passes the input register, then the output register, before it is presented.
// Messages that map to no button are dropped after the input register.
// A stall on the output backs up through the input register to in_ready_o;
// the input register still advances while the output register drains.
// Reset clears the valid flags and all four rotations to 0 degrees.
module pad_event_rotation_mapper_unit (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  pem_pkg::in_t   in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output pem_pkg::out_t  out_data_o,
  input  logic           cfg_we_i,
  input  logic [1:0]     cfg_index_i,
  input  logic [1:0]     cfg_data_i
);

  logic [1:0]      rot_q [pem_pkg::NUM_PADS];
  logic            s1_valid_q;
  pem_pkg::in_t    s1_data_q;
  logic            out_valid_q;
  pem_pkg::out_t   out_data_q;
  pem_pkg::remap_t map;
  logic            out_free, s1_adv, in_fire;

  pem_remap u_remap (
    .item_i (s1_data_q),
    .rot_i  (rot_q[s1_data_q.pad_index]),
    .map_o  (map)
  );

  assign out_free   = !out_valid_q || out_ready_i;
  assign s1_adv     = s1_valid_q && (!map.hit || out_free);
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign in_fire    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < pem_pkg::NUM_PADS; i++) rot_q[i] <= pem_pkg::ROT_0;
    end else if (cfg_we_i) begin
      rot_q[cfg_index_i] <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) s1_valid_q <= in_valid_i;
      if (out_free)   out_valid_q <= s1_valid_q && map.hit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) s1_data_q <= in_data_i;
    if (out_free && s1_valid_q && map.hit) out_data_q <= map.res;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

[rtl/pem_checker.sv]
// Port-level checker for the pad event rotation mapper, bound to the top.
// Depends on pem_pkg.
module pem_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_ready_o,
  input logic          out_valid_o,
  input logic          out_ready_i,
  input pem_pkg::out_t out_data_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // extra-row codes carry a zero row
  a_ext_row_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.grid_column[6:5] == 2'b11 |-> out_data_o.grid_row == 4'd0)
    else $error("extra-row result with nonzero row");

  // columns are grid 0..15, extra column 0x40/0x50, or extra row 0x60 and up
  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.grid_column[6:4] == 3'b000) ||
                    (out_data_o.grid_column[6:5] == 2'b11) ||
                    (out_data_o.grid_column[6:5] == 2'b10 &&
                     out_data_o.grid_column[3:0] == 4'd0))
    else $error("result column outside any mapped range");

  // with the output register empty the input is always open
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input blocked with an empty output");

  // an empty output with an idle input, followed again by both, leaves nothing in the pipe
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o && !in_valid_i ##1 !out_valid_o && !in_valid_i |=> !out_valid_o)
    else $error("result without a transaction");

endmodule

bind pad_event_rotation_mapper_unit pem_checker u_pem_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
